// ===== hw/rtl/cramp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cramp_pkg
// Shared types and constants for the colour ramp mapper.
// ----------------------------------------------------------------------------
package cramp_pkg;

   localparam int VALUE_BITS = 32;
   localparam int RGB_BITS   = 24;
   localparam int CHAN_BITS  = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_LOW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_HIGH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_LEVEL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_COUNT  = 3'd4;

   localparam logic FUNC_MAP   = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   typedef struct packed {
      logic                         func;
      logic [3:0]                   stop_index;
      logic signed [VALUE_BITS-1:0] stop_threshold;
      logic [RGB_BITS-1:0]          stop_rgb;
      logic signed [VALUE_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
      logic [CHAN_BITS-1:0] out_alpha;
   } rsp_type;

   typedef struct packed {
      logic [RGB_BITS-1:0]   prev_rgb;
      logic [RGB_BITS-1:0]   cur_rgb;
      logic [VALUE_BITS-1:0] num;
      logic [VALUE_BITS-1:0] den;
   } lerp_job_type;

endpackage

// ===== hw/rtl/cramp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cramp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cramp_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cramp_lerp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cramp_lerp
// Per-channel interpolation by shift-and-subtract, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cramp_lerp
   import cramp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  lerp_job_type        job,
   output logic                done,
   output logic [RGB_BITS-1:0] rgb
);

   typedef enum logic [1:0] {L_IDLE, L_SETUP, L_ITER} lstate_type;

   lstate_type            state_ff;
   lerp_job_type          job_ff;
   logic [1:0]            chan_ff;
   logic [3:0]            bit_ff;
   logic [9:0]            q_ff;
   logic [VALUE_BITS-1:0] r_ff;
   logic [VALUE_BITS-1:0] m_ff;
   logic [8:0]            k_ff;
   logic [7:0]            base_ff;
   logic [RGB_BITS-1:0]   rgb_ff;
   logic                  done_ff;

   logic [7:0]            p_in, c_in, res_in;
   logic [VALUE_BITS-1:0] dmr, dmm, r1, r2;
   logic [9:0]            q1, q2;

   always_comb begin
      case (chan_ff)
         2'd0: begin
            p_in = job_ff.prev_rgb[23:16];
            c_in = job_ff.cur_rgb[23:16];
         end
         2'd1: begin
            p_in = job_ff.prev_rgb[15:8];
            c_in = job_ff.cur_rgb[15:8];
         end
         default: begin
            p_in = job_ff.prev_rgb[7:0];
            c_in = job_ff.cur_rgb[7:0];
         end
      endcase

      dmr = job_ff.den - r_ff;
      if (r_ff >= dmr) begin
         r1 = r_ff - dmr;
         q1 = {q_ff[8:0], 1'b1};
      end else begin
         r1 = r_ff + r_ff;
         q1 = {q_ff[8:0], 1'b0};
      end
      dmm = job_ff.den - m_ff;
      r2  = r1;
      q2  = q1;
      if (k_ff[bit_ff]) begin
         if (m_ff == job_ff.den) begin
            q2 = q1 + 10'd1;
         end else if (r1 >= dmm) begin
            r2 = r1 - dmm;
            q2 = q1 + 10'd1;
         end else begin
            r2 = r1 + m_ff;
         end
      end
      res_in = base_ff + 8'((q2 + 10'd1) >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            L_IDLE: begin
               if (start) begin
                  job_ff   <= job;
                  chan_ff  <= 2'd0;
                  state_ff <= L_SETUP;
               end
            end
            L_SETUP: begin
               q_ff   <= '0;
               r_ff   <= '0;
               bit_ff <= 4'd8;
               if (c_in >= p_in) begin
                  k_ff    <= {c_in - p_in, 1'b0};
                  m_ff    <= job_ff.num;
                  base_ff <= p_in;
               end else begin
                  k_ff    <= {p_in - c_in, 1'b0};
                  m_ff    <= job_ff.den - job_ff.num;
                  base_ff <= c_in;
               end
               state_ff <= L_ITER;
            end
            L_ITER: begin
               q_ff   <= q2;
               r_ff   <= r2;
               bit_ff <= bit_ff - 4'd1;
               if (bit_ff == 4'd0) begin
                  case (chan_ff)
                     2'd0:    rgb_ff[23:16] <= res_in;
                     2'd1:    rgb_ff[15:8]  <= res_in;
                     default: rgb_ff[7:0]   <= res_in;
                  endcase
                  if (chan_ff == 2'd2) begin
                     done_ff  <= 1'b1;
                     state_ff <= L_IDLE;
                  end else begin
                     chan_ff  <= chan_ff + 2'd1;
                     state_ff <= L_SETUP;
                  end
               end
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign rgb  = rgb_ff;

endmodule

// ===== hw/rtl/color_ramp_mapper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_ramp_mapper_core
// A stop write lands in the stop RAM at the edge that accepts it. For a map
// beat, k <= stop count stops are walked (one RAM read a cycle), then the
// lerp runs when interpolating, and the pixel beat is registered in S_EMIT.
// One item at a time: req_ready is high only in S_IDLE.
// Synchronous reset sets the registers to defaults; stop RAM holds no reset.
// ----------------------------------------------------------------------------
module color_ramp_mapper_core
   import cramp_pkg::*;
#(
   parameter int MAX_STOPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_STOPS);
   localparam int CNT_W = $clog2(MAX_STOPS + 1);
   localparam int ENT_W = VALUE_BITS + RGB_BITS;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LERP, S_EMIT} state_type;

   state_type                    state_ff;
   logic                         ramp_mode_ff, clip_low_ff, clip_high_ff;
   logic [7:0]                   alpha_level_ff;
   logic [4:0]                   stop_count_ff;
   logic signed [VALUE_BITS-1:0] sample_ff;
   logic [IDX_W-1:0]             idx_ff;
   logic [CNT_W-1:0]             n_ff;
   logic [ENT_W-1:0]             prev_ff;
   logic [RGB_BITS-1:0]          res_rgb_ff;
   logic                         res_opaque_ff;
   logic                         rsp_valid_ff;
   rsp_type                      rsp_data_ff;
   logic                         lerp_start_ff;
   lerp_job_type                 job_ff;

   logic                         wr_en;
   logic [IDX_W-1:0]             rd_addr;
   logic [ENT_W-1:0]             rd_data;
   logic signed [VALUE_BITS-1:0] thr;
   logic signed [VALUE_BITS-1:0] prev_thr;
   logic [RGB_BITS-1:0]          col;
   logic [CNT_W-1:0]             n_in;
   logic                         lerp_done;
   logic [RGB_BITS-1:0]          lerp_rgb;

   assign req_ready = (state_ff == S_IDLE);
   assign wr_en     = req_valid && req_ready && req_data.func == FUNC_WRITE
                      && 32'(req_data.stop_index) < MAX_STOPS;
   assign rd_addr   = (state_ff == S_SCAN) ? idx_ff + IDX_W'(1) : '0;
   assign thr       = rd_data[ENT_W-1 -: VALUE_BITS];
   assign col       = rd_data[RGB_BITS-1:0];
   assign prev_thr  = prev_ff[ENT_W-1 -: VALUE_BITS];
   assign n_in      = (32'(stop_count_ff) > MAX_STOPS) ? CNT_W'(MAX_STOPS)
                                                       : CNT_W'(stop_count_ff);

   cramp_ram #(.WIDTH(ENT_W), .DEPTH(MAX_STOPS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_data.stop_index)),
      .wr_data ({req_data.stop_threshold, req_data.stop_rgb}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cramp_lerp u_lerp (
      .clock (clock),
      .reset (reset),
      .start (lerp_start_ff),
      .job   (job_ff),
      .done  (lerp_done),
      .rgb   (lerp_rgb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_mode_ff   <= 1'b1;
         clip_low_ff    <= 1'b0;
         clip_high_ff   <= 1'b0;
         alpha_level_ff <= 8'd255;
         stop_count_ff  <= 5'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RAMP_MODE:   ramp_mode_ff   <= csr_wdata[0];
            CSR_CLIP_LOW:    clip_low_ff    <= csr_wdata[0];
            CSR_CLIP_HIGH:   clip_high_ff   <= csr_wdata[0];
            CSR_ALPHA_LEVEL: alpha_level_ff <= csr_wdata;
            CSR_STOP_COUNT:  stop_count_ff  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         lerp_start_ff <= 1'b0;
      end else begin
         lerp_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_data.func == FUNC_MAP) begin
                  sample_ff <= req_data.sample;
                  n_ff      <= n_in;
                  idx_ff    <= '0;
                  if (n_in == '0) begin
                     res_opaque_ff <= 1'b0;
                     state_ff      <= S_EMIT;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               prev_ff <= rd_data;
               idx_ff  <= idx_ff + IDX_W'(1);
               if (sample_ff <= thr) begin
                  if (idx_ff == '0) begin
                     res_rgb_ff    <= col;
                     res_opaque_ff <= !(clip_low_ff && sample_ff != thr);
                     state_ff      <= S_EMIT;
                  end else if (!ramp_mode_ff) begin
                     res_rgb_ff    <= col;
                     res_opaque_ff <= 1'b1;
                     state_ff      <= S_EMIT;
                  end else begin
                     job_ff.prev_rgb <= prev_ff[RGB_BITS-1:0];
                     job_ff.cur_rgb  <= col;
                     job_ff.num      <= VALUE_BITS'(sample_ff - prev_thr);
                     job_ff.den      <= VALUE_BITS'(thr - prev_thr);
                     lerp_start_ff   <= 1'b1;
                     res_opaque_ff   <= 1'b1;
                     state_ff        <= S_LERP;
                  end
               end else if (CNT_W'(idx_ff) + CNT_W'(1) == n_ff) begin
                  res_rgb_ff    <= col;
                  res_opaque_ff <= !clip_high_ff;
                  state_ff      <= S_EMIT;
               end
            end
            S_LERP: begin
               if (lerp_done) begin
                  res_rgb_ff <= lerp_rgb;
                  state_ff   <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  if (res_opaque_ff) begin
                     rsp_data_ff <= {res_rgb_ff, alpha_level_ff};
                  end else begin
                     rsp_data_ff <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
